@@ rtl/core/dbk_pkg.sv @@
// Shared types and constants for the key debouncer core.
package dbk_pkg;

    localparam int          NUM_KEYS_DEF   = 4;
    localparam int          MASK_W         = 4;
    localparam int          CMD_W          = 3;
    localparam int          KEY_W          = 3;
    localparam int          TIME_W         = 32;
    localparam int          WINDOW_W       = 16;
    localparam logic [15:0] WINDOW_RST     = 16'd20;

    localparam logic [2:0]  CMD_EDGE        = 3'd0;
    localparam logic [2:0]  CMD_POLL        = 3'd1;
    localparam logic [2:0]  CMD_GET_PRESSED = 3'd2;
    localparam logic [2:0]  CMD_GET_STATE   = 3'd3;
    localparam logic [2:0]  CMD_RELEASE     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key_id;
        logic [TIME_W-1:0] now_time;
        logic [MASK_W-1:0] pin_levels;
    } key_in_t;

    typedef struct packed {
        logic              answer_bit;
        logic [MASK_W-1:0] state_mask;
        logic [MASK_W-1:0] pending_mask;
    } key_out_t;

    // per-lane strobes, already qualified by the accepted transaction
    typedef struct packed {
        logic edge_hit;
        logic poll;
        logic get_pressed;
        logic get_state;
        logic release_key;
    } lane_ctrl_t;

    // per-lane results after the transaction
    typedef struct packed {
        logic answer;
        logic stable;
        logic waiting;
    } lane_stat_t;

endpackage

@@ rtl/core/dbk_lane.sv @@
// One key lane: edge timestamp, debounce check and key state.
module dbk_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dbk_pkg::lane_ctrl_t           ctrl,
    input  logic [dbk_pkg::TIME_W-1:0]    now_time,
    input  logic                          pin_level,
    input  logic [dbk_pkg::WINDOW_W-1:0]  window,
    output dbk_pkg::lane_stat_t           stat
);

    logic                       stable_reg, stable_next;
    logic                       event_reg, event_next;
    logic                       waiting_reg, waiting_next;
    logic [dbk_pkg::TIME_W-1:0] edge_time_reg, edge_time_next;
    logic [dbk_pkg::TIME_W-1:0] elapsed;
    logic                       aged;
    logic                       answer;

    assign elapsed = now_time - edge_time_reg;
    assign aged    = elapsed >= {{(dbk_pkg::TIME_W-dbk_pkg::WINDOW_W){1'b0}}, window};

    always_comb begin
        stable_next    = stable_reg;
        event_next     = event_reg;
        waiting_next   = waiting_reg;
        edge_time_next = edge_time_reg;
        answer         = 1'b0;
        if (ctrl.edge_hit) begin
            waiting_next   = 1'b1;
            edge_time_next = now_time;
        end
        if (ctrl.poll && waiting_reg && aged) begin
            stable_next  = ~pin_level;
            event_next   = ~pin_level;
            waiting_next = 1'b0;
        end
        if (ctrl.get_pressed) begin
            answer     = event_reg;
            event_next = 1'b0;
        end
        if (ctrl.get_state) begin
            answer = stable_reg;
        end
        if (ctrl.release_key) begin
            stable_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg  <= 1'b0;
            event_reg   <= 1'b0;
            waiting_reg <= 1'b0;
        end else begin
            stable_reg  <= stable_next;
            event_reg   <= event_next;
            waiting_reg <= waiting_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_time_reg <= '0;
        end else begin
            edge_time_reg <= edge_time_next;
        end
    end

    assign stat.answer  = answer;
    assign stat.stable  = stable_next;
    assign stat.waiting = waiting_next;

endmodule

@@ rtl/core/dbk_merge.sv @@
// Merge stage: combines lane results into the registered result transaction.
module dbk_merge #(
    parameter int NUM_KEYS = dbk_pkg::NUM_KEYS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  dbk_pkg::lane_stat_t  stat [NUM_KEYS],
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dbk_pkg::key_out_t    m_data
);

    logic [NUM_KEYS-1:0]        answers;
    logic [dbk_pkg::MASK_W-1:0] state_mask;
    logic [dbk_pkg::MASK_W-1:0] pending_mask;
    logic                       m_valid_reg, m_valid_next;
    dbk_pkg::key_out_t          m_data_reg, m_data_next;

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_ans
            assign answers[k] = stat[k].answer;
        end
        for (k = 0; k < dbk_pkg::MASK_W; k++) begin : g_mask
            if (k < NUM_KEYS) begin : g_live
                assign state_mask[k]   = stat[k].stable;
                assign pending_mask[k] = stat[k].waiting;
            end else begin : g_none
                assign state_mask[k]   = 1'b0;
                assign pending_mask[k] = 1'b0;
            end
        end
    endgenerate

    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (in_fire) begin
            m_valid_next             = 1'b1;
            m_data_next.answer_bit   = |answers;
            m_data_next.state_mask   = state_mask;
            m_data_next.pending_mask = pending_mask;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/edge_triggered_key_debouncer_core.sv @@
// Top level of the edge-triggered key debouncer core.
//
// Input channel s_valid/s_ready/s_data carries one command transaction:
// edge, poll, get pressed, get state or release. Each accepted transaction
// yields exactly one result transaction on m_valid/m_ready/m_data with the
// answer bit and the key state and pending masks after that command.
// Every key has its own lane that compares its aged timestamp against the
// debounce window; all lanes work in the same cycle and a merge stage
// registers the combined result.
// The result is registered and valid in the cycle after acceptance.
// The single output register allows one transaction per cycle if not stalled.
// When the receiver stalls, the held result blocks s_ready until it is taken,
// and a new transaction is accepted in the same cycle the old one leaves.
// cfg_wr_en/cfg_wr_data write the debounce window, which is registered.
// Reset (aresetn low, synchronous) clears all key state, drops m_valid and
// restores the window to 20 ticks.
module edge_triggered_key_debouncer_core #(
    parameter int NUM_KEYS = dbk_pkg::NUM_KEYS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  dbk_pkg::key_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output dbk_pkg::key_out_t            m_data,
    input  logic                         cfg_wr_en,
    input  logic [dbk_pkg::WINDOW_W-1:0] cfg_wr_data
);

    logic [dbk_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic                         in_fire;
    logic                         is_edge, is_poll, is_get_pressed, is_get_state, is_release;
    dbk_pkg::lane_stat_t          stat [NUM_KEYS];

    assign window_next = cfg_wr_en ? cfg_wr_data : window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= dbk_pkg::WINDOW_RST;
        end else begin
            window_reg <= window_next;
        end
    end

    assign in_fire        = s_valid && s_ready;
    assign is_edge        = in_fire && (s_data.cmd == dbk_pkg::CMD_EDGE);
    assign is_poll        = in_fire && (s_data.cmd == dbk_pkg::CMD_POLL);
    assign is_get_pressed = in_fire && (s_data.cmd == dbk_pkg::CMD_GET_PRESSED);
    assign is_get_state   = in_fire && (s_data.cmd == dbk_pkg::CMD_GET_STATE);
    assign is_release     = in_fire && (s_data.cmd == dbk_pkg::CMD_RELEASE);

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++) begin : g_lane
            dbk_pkg::lane_ctrl_t ctrl;
            logic                sel;
            logic                pin;

            assign sel = (s_data.key_id == dbk_pkg::KEY_W'(k));

            if (k < dbk_pkg::MASK_W) begin : g_pin
                assign pin = s_data.pin_levels[k];
            end else begin : g_nopin
                assign pin = 1'b1;
            end

            assign ctrl.edge_hit    = is_edge && sel;
            assign ctrl.poll        = is_poll;
            assign ctrl.get_pressed = is_get_pressed && sel;
            assign ctrl.get_state   = is_get_state && sel;
            assign ctrl.release_key = is_release && sel;

            dbk_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .now_time  (s_data.now_time),
                .pin_level (pin),
                .window    (window_reg),
                .stat      (stat[k])
            );
        end
    endgenerate

    dbk_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .stat    (stat),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ test/edge_triggered_key_debouncer_core_tb.sv @@
// Testbench for the key debouncer core: self-checking with a built-in debounce predictor.
module edge_triggered_key_debouncer_core_tb;

    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         REPORT_LIMIT    = 10;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         HOLD_OFF_CYCLES = 40;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    dbk_pkg::key_in_t             s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    dbk_pkg::key_out_t            m_data;
    logic                         cfg_wr_en   = 1'b0;
    logic [dbk_pkg::WINDOW_W-1:0] cfg_wr_data = '0;

    // predictor state
    logic [dbk_pkg::MASK_W-1:0]   stable_keys  = '0;
    logic [dbk_pkg::MASK_W-1:0]   unread_press = '0;
    logic [dbk_pkg::MASK_W-1:0]   waiting_keys = '0;
    logic [dbk_pkg::TIME_W-1:0]   edge_stamp [dbk_pkg::MASK_W];
    logic [dbk_pkg::WINDOW_W-1:0] window_ticks = dbk_pkg::WINDOW_RST;

    dbk_pkg::key_out_t expected_results [$];
    logic [31:0]       sweep_tick      = '0;
    int                cycle_count     = 0;
    int                mismatch_count  = 0;
    int                items_sent      = 0;
    int                results_checked = 0;
    bit                tx_idle_on      = 1'b1;
    bit                rx_idle_on      = 1'b1;
    int                rx_hold_req     = 0;
    int                rx_hold_left    = 0;

    edge_triggered_key_debouncer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic dbk_pkg::key_out_t debounce_predict(input dbk_pkg::key_in_t t);
        dbk_pkg::key_out_t r;
        logic              key_ok;
        logic [31:0]       elapsed;
        r = '0;
        key_ok = t.key_id < dbk_pkg::NUM_KEYS_DEF;
        case (t.cmd)
            dbk_pkg::CMD_EDGE: begin
                if (key_ok) begin
                    waiting_keys[t.key_id] = 1'b1;
                    edge_stamp[t.key_id] = t.now_time;
                end
            end
            dbk_pkg::CMD_POLL: begin
                for (int k = 0; k < dbk_pkg::NUM_KEYS_DEF; k++) begin
                    elapsed = t.now_time - edge_stamp[k];
                    if (waiting_keys[k] && elapsed >= {16'd0, window_ticks}) begin
                        stable_keys[k] = ~t.pin_levels[k];
                        unread_press[k] = ~t.pin_levels[k];
                        waiting_keys[k] = 1'b0;
                    end
                end
            end
            dbk_pkg::CMD_GET_PRESSED: begin
                if (key_ok && unread_press[t.key_id]) begin
                    unread_press[t.key_id] = 1'b0;
                    r.answer_bit = 1'b1;
                end
            end
            dbk_pkg::CMD_GET_STATE: begin
                if (key_ok) r.answer_bit = stable_keys[t.key_id];
            end
            dbk_pkg::CMD_RELEASE: begin
                if (key_ok) stable_keys[t.key_id] = 1'b0;
            end
            default: ;
        endcase
        r.state_mask = stable_keys;
        r.pending_mask = waiting_keys;
        return r;
    endfunction

    // result checking first, then prediction for the transaction taken at this edge
    always @(posedge aclk) begin
        dbk_pkg::key_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result with no transaction pending: %p", m_data);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_data.answer_bit !== want.answer_bit ||
                        m_data.state_mask !== want.state_mask ||
                        m_data.pending_mask !== want.pending_mask) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result %0d: expected answer %b state %b ",
                                      "pending %b, got %b %b %b"},
                                     results_checked, want.answer_bit, want.state_mask,
                                     want.pending_mask, m_data.answer_bit, m_data.state_mask,
                                     m_data.pending_mask);
                    end
                end
            end
            if (s_valid && s_ready) expected_results.push_back(debounce_predict(s_data));
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 27) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] key,
                            input logic [31:0] now, input logic [3:0] pins);
        dbk_pkg::key_in_t t;
        t.cmd = cmd;
        t.key_id = key;
        t.now_time = now;
        t.pin_levels = pins;
        while (tx_idle_on && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [dbk_pkg::WINDOW_W-1:0] ticks);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window_ticks = ticks;
    endtask

    task automatic run_random(input int count);
        logic [2:0] cmd;
        logic [2:0] key;
        logic [31:0] now;
        int roll;
        int k;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 25)      cmd = dbk_pkg::CMD_EDGE;
            else if (roll < 55) cmd = dbk_pkg::CMD_POLL;
            else if (roll < 70) cmd = dbk_pkg::CMD_GET_PRESSED;
            else if (roll < 85) cmd = dbk_pkg::CMD_GET_STATE;
            else if (roll < 96) cmd = dbk_pkg::CMD_RELEASE;
            else                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            key = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 3))
                                             : 3'($urandom_range(4, 7));
            sweep_tick = sweep_tick + $urandom_range(0, int'(window_ticks) / 4 + 2);
            now = sweep_tick;
            if (cmd == dbk_pkg::CMD_POLL && $urandom_range(0, 99) < 20) begin
                // land right on or just short of one key's window
                k = $urandom_range(0, 3);
                now = edge_stamp[k] + window_ticks - $urandom_range(0, 1);
            end else if ($urandom_range(0, 99) < 4) begin
                now = $urandom();
            end
            send_cmd(cmd, key, now, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_directed_cases();
        // wrap-safe aging, boundary of the window, extremes of the time stamp
        send_cmd(dbk_pkg::CMD_EDGE, 3'd0, 32'hFFFF_FFF0, 4'hF);
        send_cmd(dbk_pkg::CMD_EDGE, 3'd1, 32'd100, 4'hF);
        send_cmd(dbk_pkg::CMD_EDGE, 3'd2, 32'd0, 4'hF);
        send_cmd(dbk_pkg::CMD_EDGE, 3'd3, 32'hFFFF_FFFF, 4'hF);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd3, 4'b1110);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd4, 4'b0000);
        send_cmd(dbk_pkg::CMD_GET_PRESSED, 3'd0, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_GET_PRESSED, 3'd0, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_GET_STATE, 3'd0, 32'd0, 4'h0);
        // repeated edge restarts the window
        send_cmd(dbk_pkg::CMD_EDGE, 3'd2, 32'd10, 4'h0);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd25, 4'b0000);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd30, 4'b1111);
        // pin high on confirmation drops an unread press
        send_cmd(dbk_pkg::CMD_EDGE, 3'd3, 32'd40, 4'h0);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd60, 4'b1000);
        send_cmd(dbk_pkg::CMD_GET_PRESSED, 3'd3, 32'd0, 4'h0);
        // release clears the level only
        send_cmd(dbk_pkg::CMD_EDGE, 3'd1, 32'd100, 4'h0);
        send_cmd(dbk_pkg::CMD_POLL, 3'd0, 32'd120, 4'b0000);
        send_cmd(dbk_pkg::CMD_EDGE, 3'd0, 32'd200, 4'h0);
        send_cmd(dbk_pkg::CMD_RELEASE, 3'd1, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_RELEASE, 3'd0, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_GET_STATE, 3'd1, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_GET_PRESSED, 3'd1, 32'd0, 4'h0);
        // keys out of range and spare commands change nothing
        send_cmd(dbk_pkg::CMD_EDGE, 3'd7, 32'hFFFF_FFFF, 4'hF);
        send_cmd(dbk_pkg::CMD_GET_STATE, 3'd4, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_GET_PRESSED, 3'd5, 32'd0, 4'h0);
        send_cmd(dbk_pkg::CMD_RELEASE, 3'd6, 32'd0, 4'h0);
        send_cmd(CMD_SPARE_FIRST, 3'd2, 32'd0, 4'h5);
        send_cmd(CMD_SPARE_FIRST + 3'd1, 3'd1, 32'd0, 4'hA);
        send_cmd(CMD_SPARE_LAST, 3'd0, 32'hFFFF_FFFF, 4'hF);
    endtask

    task automatic test_window_extremes();
        set_window(16'd0);
        run_random(90);
        set_window(16'hFFFF);
        sweep_tick = 32'hFFFE_0000;
        run_random(90);
        set_window(16'd1);
        run_random(80);
        set_window(16'($urandom_range(2, 300)));
        run_random(90);
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_req = HOLD_OFF_CYCLES;
        run_random(40);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_drain_pause();
        run_random(30);
        wait_drained();
        run_random(30);
    endtask

    task automatic test_long_random();
        set_window(dbk_pkg::WINDOW_RST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(120);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        sweep_tick = 32'hFFFF_FF00;
        run_random(160);
    endtask

    initial begin
        for (int k = 0; k < dbk_pkg::MASK_W; k++) edge_stamp[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_window_extremes();
        test_output_backpressure();
        test_sender_drain_pause();
        test_long_random();
        wait_drained();
        $display("Sent %0d transactions, checked %0d results, %0d mismatches.",
                 items_sent, results_checked, mismatch_count);
        $display("Windows 0, 1, 20, 65535 and random; time wrap, output hold-off, drain pause.");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dbk_pkg.sv
rtl/core/dbk_lane.sv
rtl/core/dbk_merge.sv
rtl/core/edge_triggered_key_debouncer_core.sv
test/edge_triggered_key_debouncer_core_tb.sv
